@@ rtl/ecal_pkg.sv @@
package ecal_pkg;

  // pipeline depth and stage indices
  localparam int unsigned NumStg  = 10;
  localparam int unsigned StgT    = 0;  // Unix seconds, format resolved
  localparam int unsigned StgU    = 1;  // biased non-negative seconds
  localparam int unsigned StgQ    = 2;  // biased day number
  localparam int unsigned StgZ    = 3;  // days since 0000-03-01, time of day
  localparam int unsigned StgEra  = 4;  // era, day of era / hours
  localparam int unsigned StgA    = 5;  // leap-corrected day of era / min, sec
  localparam int unsigned StgYoe  = 6;  // year of era
  localparam int unsigned StgDoy  = 7;  // day of March-based year
  localparam int unsigned StgMp   = 8;  // March-based month
  localparam int unsigned StgOut  = 9;  // output register

  typedef logic [NumStg-1:0] stg_vec_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  // NTP era 0 starts 2208988800 s before the Unix epoch
  localparam logic [33:0] NtpUnixDelta = 34'd2208988800;

  // 99421 whole days; lifts every 34-bit signed count above zero
  localparam logic [34:0] DayBias    = 35'd8589974400;
  // 719468 - 99421: days from 0000-03-01 to the bias origin
  localparam logic [19:0] ZBias      = 20'd620047;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [16:0] SecsPerHr  = 17'd3600;
  localparam logic [11:0] SecsPerMin = 12'd60;

  localparam logic [19:0] DaysPerEra = 20'd146097;
  localparam logic [17:0] DaysEraM1  = 18'd146096;
  localparam logic [17:0] Days100Yr  = 18'd36524;
  localparam logic [17:0] DaysPerYr  = 18'd365;
  localparam logic [8:0]  YrsPerCent = 9'd100;
  localparam logic [11:0] YrsPerEra  = 12'd400;

  // reciprocals: floor(x/d) = (x*M) >> S, exact over the stated input width
  localparam logic [28:0] Recip675  = 29'd407226529;  // 28-bit x, S=38
  localparam logic [18:0] Recip365  = 19'd367720;     // 18-bit x, S=27
  localparam logic [11:0] Recip153  = 12'd3427;       // 11-bit x, S=19
  localparam logic [13:0] Recip225  = 14'd9321;       // 13-bit x, S=21
  localparam logic [10:0] Recip15   = 11'd1093;       // 10-bit x, S=14

  function automatic logic [8:0] div365(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(Recip365);
    return p[35:27];
  endfunction

  // (153*mp + 2) / 5: first day of each March-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ecal_if.sv @@
interface ecal_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [33:0] seconds_count;

  modport source (output valid, action, seconds_count, input ready);
  modport sink   (input valid, action, seconds_count, output ready);
endinterface

interface ecal_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  second_of_minute;

  modport source (output valid, valid_res, year, month, day, hours, minutes,
                  second_of_minute, input ready);
  modport sink   (input valid, valid_res, year, month, day, hours, minutes,
                  second_of_minute, output ready);
endinterface

@@ rtl/ecal_ctrl.sv @@
module ecal_ctrl import ecal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stg_vec_t ld_o
);

  stg_vec_t          v_q, v_d;
  logic [NumStg:0]   rdy;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NumStg] = out_ready_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumStg; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ld_o        = rdy[NumStg-1:0];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStg-1];

endmodule

@@ rtl/ecal_front.sv @@
module ecal_front import ecal_pkg::*; (
  input  logic               clk_i,
  input  stg_vec_t           ld_i,
  input  logic               action_i,
  input  logic signed [33:0] seconds_count_i,
  output logic               ok_o,
  output logic [19:0]        z_o,
  output logic [16:0]        tod_o
);

  logic [31:0] ntp;
  logic [33:0] t_d, t_q;
  logic        ok_d;
  logic [34:0] u_d, u_q, u2_q;
  logic [56:0] prod;
  logic [17:0] q_d, q_q;
  logic [34:0] rem;
  logic [19:0] z_d, z_q;
  logic [16:0] tod_d, tod_q;
  logic [StgZ:StgT] ok_q;

  // NTP: clear top bit is era 1, i.e. +2^32, then shift origin to 1970
  always_comb begin
    ntp  = seconds_count_i[31:0];
    t_d  = action_i ? (34'({~ntp[31], ntp}) - NtpUnixDelta) : seconds_count_i;
    ok_d = !(action_i && (ntp == '0));
  end

  assign u_d  = 35'({t_q[33], t_q}) + DayBias;

  // u / 86400 = (u >> 7) / 675
  assign prod = 57'(u_q[34:7]) * 57'(Recip675);
  assign q_d  = prod[55:38];

  assign rem   = u2_q - 35'(q_q) * 35'(SecsPerDay);
  assign tod_d = rem[16:0];
  assign z_d   = 20'(q_q) + ZBias;

  always_ff @(posedge clk_i) begin
    if (ld_i[StgT]) begin
      t_q        <= t_d;
      ok_q[StgT] <= ok_d;
    end
    if (ld_i[StgU]) begin
      u_q        <= u_d;
      ok_q[StgU] <= ok_q[StgT];
    end
    if (ld_i[StgQ]) begin
      q_q        <= q_d;
      u2_q       <= u_q;
      ok_q[StgQ] <= ok_q[StgU];
    end
    if (ld_i[StgZ]) begin
      z_q        <= z_d;
      tod_q      <= tod_d;
      ok_q[StgZ] <= ok_q[StgQ];
    end
  end

  assign ok_o  = ok_q[StgZ];
  assign z_o   = z_q;
  assign tod_o = tod_q;

endmodule

@@ rtl/ecal_civil.sv @@
module ecal_civil import ecal_pkg::*; (
  input  logic        clk_i,
  input  stg_vec_t    ld_i,
  input  logic        ok_i,
  input  logic [19:0] z_i,
  output logic        ok_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);

  logic [StgOut:StgEra] ok_q;

  logic [2:0]  era_d, era4_q, era5_q, era6_q, era7_q, era8_q;
  logic [17:0] doe_d, doe4_q, doe5_q, doe6_q;
  logic [8:0]  c1460;
  logic [2:0]  c36524;
  logic        c146096;
  logic [17:0] a_d, a_q;
  logic [8:0]  yoe_d, yoe6_q, yoe7_q, yoe8_q;
  logic [17:0] y365;
  logic [1:0]  c100;
  logic [8:0]  doy_d, doy7_q, doy8_q;
  logic [10:0] mx;
  logic [22:0] mprod;
  logic [3:0]  mp_d, mp8_q;
  logic [11:0] year_d, year_q;
  logic [3:0]  month_d, month_q;
  logic [4:0]  day_d, day_q;

  // era and day of era
  always_comb begin
    era_d = '0;
    for (int k = 1; k <= 7; k++) begin
      if (z_i >= 20'(k) * DaysPerEra) era_d = 3'(k);
    end
    doe_d = 18'(z_i - 20'(era_d) * DaysPerEra);
  end

  // remove leap days: doe/1460 taken as (doe>>2)/365
  always_comb begin
    c1460  = div365({2'b00, doe4_q[17:2]});
    c36524 = '0;
    for (int k = 1; k <= 4; k++) begin
      if (doe4_q >= 18'(k) * Days100Yr) c36524 = 3'(k);
    end
    c146096 = (doe4_q == DaysEraM1);
    a_d = doe4_q - 18'(c1460) + 18'(c36524) - 18'(c146096);
  end

  assign yoe_d = div365(a_q);

  always_comb begin
    y365 = 18'(yoe6_q) * DaysPerYr;
    c100 = '0;
    for (int k = 1; k <= 3; k++) begin
      if (yoe6_q >= 9'(k) * YrsPerCent) c100 = 2'(k);
    end
    doy_d = 9'(doe6_q - y365 - 18'(yoe6_q[8:2]) + 18'(c100));
  end

  // March-based month
  assign mx    = 11'(doy7_q) * 11'd5 + 11'd2;
  assign mprod = 23'(mx) * 23'(Recip153);
  assign mp_d  = mprod[22:19];

  // Jan and Feb belong to the next civil year
  always_comb begin
    day_d   = 5'(doy8_q - month_start(mp8_q) + 9'd1);
    month_d = (mp8_q < 4'd10) ? (mp8_q + 4'd3) : (mp8_q - 4'd9);
    year_d  = 12'(yoe8_q) + 12'(era8_q) * YrsPerEra + 12'(mp8_q >= 4'd10);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[StgEra]) begin
      era4_q       <= era_d;
      doe4_q       <= doe_d;
      ok_q[StgEra] <= ok_i;
    end
    if (ld_i[StgA]) begin
      a_q        <= a_d;
      doe5_q     <= doe4_q;
      era5_q     <= era4_q;
      ok_q[StgA] <= ok_q[StgEra];
    end
    if (ld_i[StgYoe]) begin
      yoe6_q       <= yoe_d;
      doe6_q       <= doe5_q;
      era6_q       <= era5_q;
      ok_q[StgYoe] <= ok_q[StgA];
    end
    if (ld_i[StgDoy]) begin
      doy7_q       <= doy_d;
      yoe7_q       <= yoe6_q;
      era7_q       <= era6_q;
      ok_q[StgDoy] <= ok_q[StgYoe];
    end
    if (ld_i[StgMp]) begin
      mp8_q       <= mp_d;
      doy8_q      <= doy7_q;
      yoe8_q      <= yoe7_q;
      era8_q      <= era7_q;
      ok_q[StgMp] <= ok_q[StgDoy];
    end
    if (ld_i[StgOut]) begin
      year_q       <= year_d;
      month_q      <= month_d;
      day_q        <= day_d;
      ok_q[StgOut] <= ok_q[StgMp];
    end
  end

  assign ok_o    = ok_q[StgOut];
  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

@@ rtl/ecal_tod.sv @@
module ecal_tod import ecal_pkg::*; (
  input  logic        clk_i,
  input  stg_vec_t    ld_i,
  input  logic [16:0] tod_i,
  output hms_t        hms_o
);

  logic [26:0] hprod;
  logic [4:0]  hr_d, hr_q;
  logic [11:0] rem_d, rem_q;
  logic [20:0] mprod;
  logic [5:0]  min;
  hms_t        hms_d;
  hms_t        hms_q [StgA:StgOut];

  // tod / 3600 = (tod >> 4) / 225
  assign hprod = 27'(tod_i[16:4]) * 27'(Recip225);
  assign hr_d  = hprod[25:21];
  assign rem_d = 12'(tod_i - 17'(hr_d) * SecsPerHr);

  // rem / 60 = (rem >> 2) / 15
  always_comb begin
    mprod         = 21'(rem_q[11:2]) * 21'(Recip15);
    min           = mprod[19:14];
    hms_d.hours   = hr_q;
    hms_d.minutes = min;
    hms_d.seconds = 6'(rem_q - 12'(min) * SecsPerMin);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[StgEra]) begin
      hr_q  <= hr_d;
      rem_q <= rem_d;
    end
    if (ld_i[StgA]) begin
      hms_q[StgA] <= hms_d;
    end
    for (int k = StgYoe; k <= StgOut; k++) begin
      if (ld_i[k]) hms_q[k] <= hms_q[k-1];
    end
  end

  assign hms_o = hms_q[StgOut];

endmodule

@@ rtl/epoch_seconds_to_calendar.sv @@
// Seconds count to UTC calendar date and time of day. Each input beat carries
// a 34-bit count and a format select: action=0 takes the count as signed Unix
// seconds, action=1 takes its low 32 bits as an NTP seconds value (top bit
// clear means the 2036 era) and moves it to the Unix origin. An NTP value of
// zero gives valid_res=0 with all date and time fields zero. Dates follow the
// proleptic Gregorian calendar; times before 1970 floor to the earlier day.
// The block is a 10-stage pipeline that accepts one beat per cycle unless a
// stalled output has backed up every stage. A result is presented on the
// output from the output register once its beat has passed through all the
// stages. The depth is set by the chain of constant divisions (86400, era,
// 365, month), each in its own stage: the era by compares against its
// multiples, the others as reciprocal multiplies. Results leave in acceptance
// order. Back-pressure propagates stage by stage, so empty stages keep filling
// while the output register waits. No state beyond the pipeline.
module epoch_seconds_to_calendar import ecal_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ecal_in_if.sink       in_i,
  ecal_out_if.source    out_o
);

  stg_vec_t    ld;
  logic        ok_front;
  logic [19:0] z;
  logic [16:0] tod;
  logic        ok_out;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  hms_t        hms;

  // handshake and per-stage load enables
  ecal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ld_o        (ld)
  );

  // stages 0-3: format, bias, day split
  ecal_front u_front (
    .clk_i           (clk_i),
    .ld_i            (ld),
    .action_i        (in_i.action),
    .seconds_count_i (in_i.seconds_count),
    .ok_o            (ok_front),
    .z_o             (z),
    .tod_o           (tod)
  );

  // stages 4-9: days since 0000-03-01 to year/month/day
  ecal_civil u_civil (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .ok_i    (ok_front),
    .z_i     (z),
    .ok_o    (ok_out),
    .year_o  (year),
    .month_o (month),
    .day_o   (day)
  );

  // stages 4-9: seconds of day to h/m/s, delayed to line up with the date
  ecal_tod u_tod (
    .clk_i (clk_i),
    .ld_i  (ld),
    .tod_i (tod),
    .hms_o (hms)
  );

  // a zero NTP value forces every field to zero
  assign out_o.valid_res        = ok_out;
  assign out_o.year             = ok_out ? year        : '0;
  assign out_o.month            = ok_out ? month       : '0;
  assign out_o.day              = ok_out ? day         : '0;
  assign out_o.hours            = ok_out ? hms.hours   : '0;
  assign out_o.minutes          = ok_out ? hms.minutes : '0;
  assign out_o.second_of_minute = ok_out ? hms.seconds : '0;

endmodule
